// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on aclk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ----- src/icm_pkg.sv -----
// ----------------------------------------------------------------------------
// icm_pkg
// shared codes, constants and types of the window filter
// ----------------------------------------------------------------------------
package icm_pkg;

    localparam int CMD_BITS       = 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int WIDX_IN_BITS   = 8;
    localparam int WEIGHT_BITS    = 16;
    localparam int HEIGHT_BITS    = 13;
    localparam int ROW_BITS       = 12;
    localparam int KSIZE_BITS     = 4;
    localparam int MODE_BITS      = 2;
    localparam int RADIUS_BITS    = 3;
    localparam int FRAC_BITS      = 12;
    localparam int HEIGHT_LIMIT   = 4096;

    localparam logic [CMD_BITS-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_PIXEL = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_DRAIN = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_NOP   = 2'd3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_KSIZE  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BIAS   = 3'd4;

    localparam logic [MODE_BITS-1:0] MODE_CONV   = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_ERODE  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_DILATE = 2'd2;

    localparam logic signed [WEIGHT_BITS-1:0] ONE_Q = 16'sd4096;

    typedef struct packed {
        logic valid;
        logic last;
    } icm_tap_t;

endpackage

// ----- src/icm_ram.sv -----
// ----------------------------------------------------------------------------
// icm_ram
// generic simple dual-port ram, one write port, registered read
// ----------------------------------------------------------------------------
module icm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/icm_addr.sv -----
// ----------------------------------------------------------------------------
// icm_addr
// tap address stages: clamp-to-edge source position, then linear address
// ----------------------------------------------------------------------------
module icm_addr #(
    parameter int XW  = 11,
    parameter int CW  = 12,
    parameter int WIW = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  icm_pkg::icm_tap_t                tap_in,
    input  logic [WIW-1:0]                   widx_in,
    input  logic [icm_pkg::KSIZE_BITS-1:0]   tx,
    input  logic [icm_pkg::KSIZE_BITS-1:0]   ty,
    input  logic [XW-1:0]                    ox,
    input  logic [icm_pkg::ROW_BITS-1:0]     oy,
    input  logic [icm_pkg::RADIUS_BITS-1:0]  radius,
    input  logic [CW-1:0]                    img_width,
    input  logic [icm_pkg::HEIGHT_BITS-1:0]  img_height,
    output icm_pkg::icm_tap_t                tap_out,
    output logic [WIW-1:0]                   widx_out,
    output logic [icm_pkg::ROW_BITS+CW-1:0]  lin_out
);

    localparam int RB = icm_pkg::ROW_BITS;
    localparam int LW = RB + CW;

    logic signed [XW+1:0] sx_s;
    logic signed [RB+1:0] sy_s;
    logic [CW-1:0]        wm1;
    logic [icm_pkg::HEIGHT_BITS-1:0] hm1;
    logic [XW-1:0]        sx_next, sx_reg;
    logic [RB-1:0]        sy_next, sy_reg;
    icm_pkg::icm_tap_t    tap1_reg, tap2_reg;
    logic [WIW-1:0]       widx1_reg, widx2_reg;
    logic [LW-1:0]        lin_next, lin_reg;

    assign wm1 = img_width - CW'(1);
    assign hm1 = img_height - icm_pkg::HEIGHT_BITS'(1);

    // source column/row is output position minus tap offset (flipped kernel)
    always_comb begin
        sx_s = {2'b00, ox} + {{(XW-1){1'b0}}, radius} - {{(XW-2){1'b0}}, tx};
        sy_s = {2'b00, oy} + {{(RB-1){1'b0}}, radius} - {{(RB-2){1'b0}}, ty};
        if (sx_s[XW+1]) begin
            sx_next = '0;
        end else if (32'(sx_s[XW:0]) > 32'(wm1)) begin
            sx_next = XW'(wm1);
        end else begin
            sx_next = sx_s[XW-1:0];
        end
        if (sy_s[RB+1]) begin
            sy_next = '0;
        end else if (32'(sy_s[RB:0]) > 32'(hm1)) begin
            sy_next = RB'(hm1);
        end else begin
            sy_next = sy_s[RB-1:0];
        end
        lin_next = LW'(sy_reg) * LW'(img_width) + LW'(sx_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap1_reg <= '0;
            tap2_reg <= '0;
        end else begin
            tap1_reg <= tap_in;
            tap2_reg <= tap1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        widx1_reg <= widx_in;
        widx2_reg <= widx1_reg;
        lin_reg   <= lin_next;
    end

    assign tap_out  = tap2_reg;
    assign widx_out = widx2_reg;
    assign lin_out  = lin_reg;

endmodule

// ----- src/icm_lane.sv -----
// ----------------------------------------------------------------------------
// icm_lane
// one color channel: multiply-accumulate or running min/max over the taps
// ----------------------------------------------------------------------------
module icm_lane #(
    parameter int SB = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic [icm_pkg::MODE_BITS-1:0]         mode,
    input  logic signed [icm_pkg::WEIGHT_BITS-1:0] bias,
    input  icm_pkg::icm_tap_t                     tap,
    input  logic signed [SB-1:0]                  pix,
    input  logic signed [icm_pkg::WEIGHT_BITS-1:0] wt,
    output logic                                  done,
    output logic [SB-1:0]                         result
);

    localparam int WB    = icm_pkg::WEIGHT_BITS;
    localparam int PW    = SB + WB;
    localparam int ACC_W = SB + 25;
    localparam logic signed [ACC_W-1:0] SMAX_A = {{(ACC_W-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SMIN_A = {{(ACC_W-SB+1){1'b1}}, {(SB-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) <<< (icm_pkg::FRAC_BITS - 1);
    localparam logic signed [SB-1:0] SMAX_S = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SMIN_S = {1'b1, {(SB-1){1'b0}}};

    icm_pkg::icm_tap_t       tap_reg;
    logic                    done_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [SB-1:0]    pix_reg;
    logic                    en_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [SB-1:0]    mm_reg, mm_next;
    logic signed [ACC_W-1:0] rnd, quo;
    logic signed [SB-1:0]    sat;

    always_comb begin
        acc_next = acc_reg;
        mm_next  = mm_reg;
        if (start) begin
            acc_next = {{(ACC_W-WB){bias[WB-1]}}, bias} <<< icm_pkg::FRAC_BITS;
            mm_next  = (mode == icm_pkg::MODE_ERODE) ? SMAX_S : SMIN_S;
        end else if (tap_reg.valid && en_reg) begin
            acc_next = acc_reg + {{(ACC_W-PW){prod_reg[PW-1]}}, prod_reg};
            if (mode == icm_pkg::MODE_ERODE) begin
                mm_next = (pix_reg < mm_reg) ? pix_reg : mm_reg;
            end else begin
                mm_next = (pix_reg > mm_reg) ? pix_reg : mm_reg;
            end
        end
    end

    // round half up, then saturate
    always_comb begin
        rnd = acc_reg + HALF;
        quo = rnd >>> icm_pkg::FRAC_BITS;
        if (quo > SMAX_A) begin
            sat = SMAX_S;
        end else if (quo < SMIN_A) begin
            sat = SMIN_S;
        end else begin
            sat = quo[SB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            tap_reg  <= tap;
            done_reg <= tap_reg.valid && tap_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= pix * wt;
        pix_reg  <= pix;
        en_reg   <= (wt != '0);
        acc_reg  <= acc_next;
        mm_reg   <= mm_next;
    end

    assign done   = done_reg;
    assign result = (mode == icm_pkg::MODE_CONV) ? sat : mm_reg;

endmodule

// ----- src/icm_merge.sv -----
// ----------------------------------------------------------------------------
// icm_merge
// joins the four lane results into one output beat and holds it
// ----------------------------------------------------------------------------
module icm_merge #(
    parameter int SB    = 16,
    parameter int OUT_W = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  logic [SB-1:0] red,
    input  logic [SB-1:0] green,
    input  logic [SB-1:0] blue,
    input  logic [SB-1:0] alpha,
    input  logic          last,
    output logic          free,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [OUT_W-1:0] m_tdata,
    output logic          m_tlast
);

    logic             valid_reg, valid_next;
    logic [OUT_W-1:0] data_reg;
    logic             last_reg;

    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= OUT_W'({alpha, blue, green, red});
            last_reg <= last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

// ----- src/image_convolve_morphology_top.sv -----
// ----------------------------------------------------------------------------
// image_convolve_morphology_top
// streaming rgba window filter: convolution, erode, dilate, clamped edges
// ----------------------------------------------------------------------------
//  port group | dir | carries
//  s_*        | in  | tuser: command; tdata: weight_index, weight_value, r, g, b, a
//  m_*        | out | tdata: r, g, b, a; tlast: frame_last
//  cfg_*      | in  | register index and write data
//
//  weight load and no-op beats are taken in idle and leave the block idle.
//  a pixel or drain beat moves to a check; if an output can be released, the
//  tap engine reads one pixel and one weight per tap from the line store and the
//  weight store, all four channel lanes in parallel.
//  otherwise a pixel or drain beat returns to idle; no beat is taken outside idle.
//  the output register lets a finished result wait while the next beat is taken.
//  reset is synchronous; the line store holds no reset state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module image_convolve_morphology_top #(
    parameter int MAX_KERNEL  = 15,
    parameter int MAX_WIDTH   = 2048,
    parameter int SAMPLE_BITS = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // weight_index, weight_value, red_in, green_in, blue_in, alpha_in, zero pad
    input  logic [((24+4*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // command
    input  logic [icm_pkg::CMD_BITS-1:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // red_out, green_out, blue_out, alpha_out, zero pad
    output logic [((4*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
    output logic m_tlast,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [icm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [icm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int SB        = SAMPLE_BITS;
    localparam int OUT_W     = ((4*SB+7)/8)*8;
    localparam int CW        = $clog2(MAX_WIDTH+1);
    localparam int XW        = $clog2(MAX_WIDTH);
    localparam int RB        = icm_pkg::ROW_BITS;
    localparam int HB        = icm_pkg::HEIGHT_BITS;
    localparam int KB        = icm_pkg::KSIZE_BITS;
    localparam int WB        = icm_pkg::WEIGHT_BITS;
    localparam int LW        = RB + CW;
    localparam int AW        = $clog2((MAX_KERNEL-1)*(MAX_WIDTH+1)+1);
    localparam int PD        = 1 << AW;
    localparam int WD        = MAX_KERNEL*MAX_KERNEL;
    localparam int WIW       = $clog2(WD);
    localparam int KMAX_ODD  = (MAX_KERNEL-1) | 1;
    localparam int WIDTH_RST = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    // configuration
    logic [CW-1:0]  width_reg, width_next;
    logic [HB-1:0]  height_reg, height_next;
    logic [KB-1:0]  ksize_reg, ksize_next;
    logic [icm_pkg::MODE_BITS-1:0] mode_reg, mode_next;
    logic signed [WB-1:0] bias_reg, bias_next;
    logic cfg_wr, restart_cfg;
    logic [11:0] cfg_w;
    logic [HB-1:0] cfg_h;
    logic [KB-1:0] cfg_k;

    // positions and control
    logic [2:0]     state_reg, state_next;
    logic [XW-1:0]  col_reg, col_next;
    logic [RB-1:0]  row_reg, row_next;
    logic           done_reg, done_next;
    logic [AW-1:0]  wr_addr_reg, wr_addr_next;
    logic [XW-1:0]  ox_reg, ox_next;
    logic [RB-1:0]  oy_reg, oy_next;
    logic [KB-1:0]  tx_reg, tx_next, ty_reg, ty_next;
    logic [WIW-1:0] widx_reg, widx_next;
    logic           flast_reg, flast_next;
    logic [WD-1:0]  wvalid_reg, wvalid_next;

    logic in_acc;
    logic [icm_pkg::CMD_BITS-1:0] cmd;
    logic [icm_pkg::WIDX_IN_BITS-1:0] in_widx;
    logic [WB-1:0] in_wval;
    logic [4*SB-1:0] in_pix;
    logic [icm_pkg::RADIUS_BITS-1:0] radius;
    logic [7:0] ksq, center8;
    logic [CW-1:0] wm1;
    logic [HB-1:0] hm1;
    logic [XW:0] rx_sum, rx;
    logic [HB-1:0] ry_sum, ry;
    logic out_ready, tap_last, start, pix_we, w_we, out_load, out_free;
    icm_pkg::icm_tap_t tap0, tap2, tap3_reg;
    logic [WIW-1:0] widx2;
    logic [LW-1:0]  lin2;
    logic [4*SB-1:0] pix_rdata;
    logic [WB-1:0]   w_rdata;
    logic wv3_reg, wc3_reg;
    logic signed [WB-1:0] wt3;
    logic [3:0] lane_done;
    logic [SB-1:0] lane_res [4];

    assign cmd     = s_tuser;
    assign in_widx = s_tdata[7:0];
    assign in_wval = s_tdata[23:8];
    assign in_pix  = s_tdata[24 +: 4*SB];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    assign radius  = ksize_reg[KB-1:1];
    assign ksq     = 8'(ksize_reg) * 8'(ksize_reg);
    assign center8 = 8'(radius) * 8'(ksize_reg) + 8'(radius);
    assign wm1     = width_reg - CW'(1);
    assign hm1     = height_reg - HB'(1);

    // register writes; a kernel size write also restores the identity kernel
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        ksize_next  = ksize_reg;
        mode_next   = mode_reg;
        bias_next   = bias_reg;
        restart_cfg = 1'b0;
        cfg_w = cfg_data[11:0];
        cfg_h = cfg_data[HB-1:0];
        cfg_k = {cfg_data[KB-1:1], 1'b1};
        if (cfg_wr) begin
            unique case (cfg_index)
                icm_pkg::CFG_WIDTH: begin
                    restart_cfg = 1'b1;
                    if (cfg_w == '0) begin
                        width_next = CW'(1);
                    end else if (32'(cfg_w) > MAX_WIDTH) begin
                        width_next = CW'(MAX_WIDTH);
                    end else begin
                        width_next = CW'(cfg_w);
                    end
                end
                icm_pkg::CFG_HEIGHT: begin
                    restart_cfg = 1'b1;
                    if (cfg_h == '0) begin
                        height_next = HB'(1);
                    end else if (32'(cfg_h) > icm_pkg::HEIGHT_LIMIT) begin
                        height_next = HB'(icm_pkg::HEIGHT_LIMIT);
                    end else begin
                        height_next = cfg_h;
                    end
                end
                icm_pkg::CFG_KSIZE: begin
                    restart_cfg = 1'b1;
                    if (cfg_k < KB'(3)) begin
                        ksize_next = KB'(3);
                    end else if (32'(cfg_k) > KMAX_ODD) begin
                        ksize_next = KB'(KMAX_ODD);
                    end else begin
                        ksize_next = cfg_k;
                    end
                end
                icm_pkg::CFG_MODE: begin
                    mode_next = (cfg_data[1:0] > icm_pkg::MODE_DILATE) ?
                                icm_pkg::MODE_DILATE : cfg_data[1:0];
                end
                icm_pkg::CFG_BIAS: begin
                    bias_next = cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // the next output needs its bottom-right source pixel already stored
    always_comb begin
        rx_sum = (XW+1)'(ox_reg) + (XW+1)'(radius);
        rx     = (32'(rx_sum) > 32'(wm1)) ? (XW+1)'(wm1) : rx_sum;
        ry_sum = HB'(oy_reg) + HB'(radius);
        ry     = (ry_sum > hm1) ? hm1 : ry_sum;
        out_ready = done_reg || (ry < HB'(row_reg)) ||
                    ((ry == HB'(row_reg)) && (rx < (XW+1)'(col_reg)));
    end

    assign tap_last = (tx_reg == ksize_reg - KB'(1)) && (ty_reg == ksize_reg - KB'(1));
    assign w_we     = in_acc && (cmd == icm_pkg::CMD_LOAD) && (in_widx < ksq);
    assign pix_we   = in_acc && (cmd == icm_pkg::CMD_PIXEL) && !done_reg;
    assign start    = (state_reg == ST_CHECK) && out_ready;
    assign out_load = (state_reg == ST_FIN) && out_free;

    always_comb begin
        state_next   = state_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        done_next    = done_reg;
        wr_addr_next = wr_addr_reg;
        ox_next      = ox_reg;
        oy_next      = oy_reg;
        tx_next      = tx_reg;
        ty_next      = ty_reg;
        widx_next    = widx_reg;
        flast_next   = flast_reg;
        wvalid_next  = wvalid_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (cmd)
                        icm_pkg::CMD_LOAD: begin
                            if (w_we) begin
                                wvalid_next[in_widx[WIW-1:0]] = 1'b1;
                            end
                        end
                        icm_pkg::CMD_PIXEL: begin
                            state_next = ST_CHECK;
                            if (pix_we) begin
                                wr_addr_next = wr_addr_reg + AW'(1);
                                if (CW'(col_reg) + CW'(1) == width_reg) begin
                                    col_next = '0;
                                    if (HB'(row_reg) + HB'(1) == height_reg) begin
                                        row_next  = '0;
                                        done_next = 1'b1;
                                    end else begin
                                        row_next = row_reg + RB'(1);
                                    end
                                end else begin
                                    col_next = col_reg + XW'(1);
                                end
                            end
                        end
                        icm_pkg::CMD_DRAIN: begin
                            state_next = ST_CHECK;
                        end
                        icm_pkg::CMD_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CHECK: begin
                if (out_ready) begin
                    state_next = ST_RUN;
                    tx_next    = '0;
                    ty_next    = '0;
                    widx_next  = '0;
                    flast_next = (ox_reg == XW'(wm1)) && (HB'(oy_reg) == hm1);
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_RUN: begin
                widx_next = widx_reg + WIW'(1);
                if (tx_reg == ksize_reg - KB'(1)) begin
                    tx_next = '0;
                    ty_next = ty_reg + KB'(1);
                end else begin
                    tx_next = tx_reg + KB'(1);
                end
                if (tap_last) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (&lane_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                    if (flast_reg) begin
                        col_next     = '0;
                        row_next     = '0;
                        done_next    = 1'b0;
                        wr_addr_next = '0;
                        ox_next      = '0;
                        oy_next      = '0;
                    end else if (ox_reg == XW'(wm1)) begin
                        ox_next = '0;
                        oy_next = oy_reg + RB'(1);
                    end else begin
                        ox_next = ox_reg + XW'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (restart_cfg) begin
            col_next     = '0;
            row_next     = '0;
            done_next    = 1'b0;
            wr_addr_next = '0;
            ox_next      = '0;
            oy_next      = '0;
        end
        if (cfg_wr && (cfg_index == icm_pkg::CFG_KSIZE)) begin
            wvalid_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= CW'(WIDTH_RST);
            height_reg  <= HB'(1080);
            ksize_reg   <= KB'(3);
            mode_reg    <= icm_pkg::MODE_CONV;
            bias_reg    <= '0;
            state_reg   <= ST_IDLE;
            col_reg     <= '0;
            row_reg     <= '0;
            done_reg    <= 1'b0;
            wr_addr_reg <= '0;
            ox_reg      <= '0;
            oy_reg      <= '0;
            tx_reg      <= '0;
            ty_reg      <= '0;
            widx_reg    <= '0;
            flast_reg   <= 1'b0;
            wvalid_reg  <= '0;
            tap3_reg    <= '0;
        end else begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            ksize_reg   <= ksize_next;
            mode_reg    <= mode_next;
            bias_reg    <= bias_next;
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            done_reg    <= done_next;
            wr_addr_reg <= wr_addr_next;
            ox_reg      <= ox_next;
            oy_reg      <= oy_next;
            tx_reg      <= tx_next;
            ty_reg      <= ty_next;
            widx_reg    <= widx_next;
            flast_reg   <= flast_next;
            wvalid_reg  <= wvalid_next;
            tap3_reg    <= tap2;
        end
    end

    assign tap0.valid = (state_reg == ST_RUN);
    assign tap0.last  = tap_last;

    icm_addr #(
        .XW  (XW),
        .CW  (CW),
        .WIW (WIW)
    ) u_addr (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tap_in     (tap0),
        .widx_in    (widx_reg),
        .tx         (tx_reg),
        .ty         (ty_reg),
        .ox         (ox_reg),
        .oy         (oy_reg),
        .radius     (radius),
        .img_width  (width_reg),
        .img_height (height_reg),
        .tap_out    (tap2),
        .widx_out   (widx2),
        .lin_out    (lin2)
    );

    icm_ram #(
        .WIDTH (4*SB),
        .DEPTH (PD)
    ) u_line_store (
        .aclk  (aclk),
        .we    (pix_we),
        .waddr (wr_addr_reg),
        .wdata (in_pix),
        .raddr (lin2[AW-1:0]),
        .rdata (pix_rdata)
    );

    icm_ram #(
        .WIDTH (WB),
        .DEPTH (WD)
    ) u_weight_store (
        .aclk  (aclk),
        .we    (w_we),
        .waddr (in_widx[WIW-1:0]),
        .wdata (in_wval),
        .raddr (widx2),
        .rdata (w_rdata)
    );

    // unwritten weights read as the identity kernel
    always_ff @(posedge aclk) begin
        wv3_reg <= wvalid_reg[widx2];
        wc3_reg <= (widx2 == WIW'(center8));
    end

    assign wt3 = wv3_reg ? w_rdata : (wc3_reg ? icm_pkg::ONE_Q : '0);

    for (genvar g = 0; g < 4; g++) begin : g_lane
        icm_lane #(
            .SB (SB)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (start),
            .mode    (mode_reg),
            .bias    (bias_reg),
            .tap     (tap3_reg),
            .pix     (pix_rdata[g*SB +: SB]),
            .wt      (wt3),
            .done    (lane_done[g]),
            .result  (lane_res[g])
        );
    end

    icm_merge #(
        .SB    (SB),
        .OUT_W (OUT_W)
    ) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .red      (lane_res[0]),
        .green    (lane_res[1]),
        .blue     (lane_res[2]),
        .alpha    (lane_res[3]),
        .last     (flast_reg),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `ASSERT_CLK(a_done_in_wait, (lane_done[0] |-> (state_reg == ST_WAIT)), "lane finished outside wait")
    `ASSERT_CLK(a_tap_bound, ((state_reg == ST_RUN) |-> (8'(widx_reg) < ksq)), "tap index past kernel")
    `ASSERT_CLK(a_col_bound, (32'(col_reg) < 32'(width_reg)), "input column past row end")

endmodule
